/* src/ozpu_pkg.sv */
`default_nettype none
package ozpu_pkg;

  localparam int FRACTION_BITS = 8;
  localparam int CORDIC_STEPS  = 16;
  localparam int CordicIters   = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

  localparam logic signed [31:0] VIEW_X_RST = 32'sd0;
  localparam logic signed [31:0] VIEW_Y_RST = 32'(1600 * (1 << FRACTION_BITS));
  localparam logic signed [31:0] VIEW_Z_RST = 32'(-662 * (1 << FRACTION_BITS));
  localparam logic signed [31:0] AIM_X_RST  = 32'sd0;
  localparam logic signed [31:0] AIM_Y_RST  = 32'(60 * (1 << FRACTION_BITS));
  localparam logic signed [31:0] AIM_Z_RST  = 32'sd0;

  localparam logic signed [31:0] GAIN_Q30     = 32'sd652032874;
  localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [33:0] HALF_TURN    = 34'sd2147483648;

  localparam logic [1:0] OP_MOVE   = 2'd0;
  localparam logic [1:0] OP_ZOOM   = 2'd1;
  localparam logic [1:0] OP_ROTATE = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] delta_x;
    logic signed [31:0] delta_y;
    logic signed [31:0] delta_z;
    logic signed [31:0] zoom_amount;
    logic signed [15:0] rotation_angle;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] view_x;
    logic signed [31:0] view_y;
    logic signed [31:0] view_z;
    logic signed [31:0] aim_x;
    logic signed [31:0] aim_y;
    logic signed [31:0] aim_z;
    logic               skipped;
  } out_word_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MOVE, ST_ZPREP, ST_ZSQ, ST_ZSUM, ST_ZSQRT, ST_ZMUL, ST_ZDINIT,
    ST_ZDIV, ST_ZUPD, ST_RPREP, ST_RMULX, ST_RMULZ, ST_RSCALE, ST_RCORD, ST_RUPD,
    ST_DONE
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -40'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [29:0] atan_lut(input logic [4:0] i);
    case (i)
      5'd0:  return 30'h20000000;
      5'd1:  return 30'h12E4051E;
      5'd2:  return 30'h09FB385B;
      5'd3:  return 30'h051111D4;
      5'd4:  return 30'h028B0D43;
      5'd5:  return 30'h0145D7E1;
      5'd6:  return 30'h00A2F61E;
      5'd7:  return 30'h00517C55;
      5'd8:  return 30'h0028BE53;
      5'd9:  return 30'h00145F2F;
      5'd10: return 30'h000A2F98;
      5'd11: return 30'h000517CC;
      5'd12: return 30'h00028BE6;
      5'd13: return 30'h000145F3;
      5'd14: return 30'h0000A2FA;
      5'd15: return 30'h0000517D;
      5'd16: return 30'h000028BE;
      5'd17: return 30'h0000145F;
      5'd18: return 30'h00000A30;
      5'd19: return 30'h00000518;
      5'd20: return 30'h0000028C;
      5'd21: return 30'h00000146;
      5'd22: return 30'h000000A3;
      5'd23: return 30'h00000051;
      default: return 30'h0;
    endcase
  endfunction

endpackage
`default_nettype wire

/* src/orbit_zoom_point_update.sv */
// Orbit camera point update.
// Input channel in_valid/in_stall/in_data carries one command word: move,
// zoom toward the aim point, or rotate about the vertical axis through it.
// Output channel out_valid/out_stall/out_data returns the viewpoint and aim
// point after the command, plus a skipped flag for zero-length zoom/rotate.
// One word is processed at a time; in_stall is high from acceptance until
// the result is loaded into the output register.
// A zoom runs a 32-step square root and three 32-step shift-subtract
// divisions; the squares and products come from one shared multiplier.
// The result register holds while out_stall is high; the block finishes its
// work and waits for the register to free before returning to idle.
// Reset restores viewpoint (0,1600,-662) and aim point (0,60,0) in Q23.8
// and empties the output register.
`default_nettype none
module orbit_zoom_point_update (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  ozpu_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output ozpu_pkg::out_word_t out_data
);
  import ozpu_pkg::*;

  state_t             state_r, state_nxt;
  in_word_t           item_r, item_nxt;
  logic signed [31:0] view_r [3];
  logic signed [31:0] view_nxt [3];
  logic signed [31:0] aim_r [3];
  logic signed [31:0] aim_nxt [3];
  logic               skip_r, skip_nxt;
  logic [1:0]         idx_r, idx_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic signed [30:0] ds_r [3];
  logic signed [30:0] ds_nxt [3];
  logic [61:0]        sum_r, sum_nxt;
  logic signed [64:0] prod_r, prod_nxt;
  logic [62:0]        n_r, n_nxt;
  logic [62:0]        rt_r, rt_nxt;
  logic [62:0]        bit_r, bit_nxt;
  logic [31:0]        rem_r, rem_nxt;
  logic [31:0]        qsh_r, qsh_nxt;
  logic               neg_r, neg_nxt;
  logic signed [51:0] cx_r, cx_nxt;
  logic signed [51:0] cz_r, cz_nxt;
  logic signed [33:0] ang_r, ang_nxt;
  logic signed [32:0] xo_r, xo_nxt;
  logic signed [32:0] zo_r, zo_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_data_r, out_data_nxt;

  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [32:0] d [3];
  logic [32:0]        dmag [3];
  logic [32:0]        mx;
  logic [62:0]        trial;
  logic [32:0]        dtrial;
  logic [61:0]        pmag;
  logic signed [64:0] prnd;
  logic signed [51:0] cxv, czv, dx, dz;
  logic signed [51:0] rxs, rzs;
  logic signed [32:0] qs;
  logic signed [33:0] at;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      view_r[0]   <= VIEW_X_RST;
      view_r[1]   <= VIEW_Y_RST;
      view_r[2]   <= VIEW_Z_RST;
      aim_r[0]    <= AIM_X_RST;
      aim_r[1]    <= AIM_Y_RST;
      aim_r[2]    <= AIM_Z_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      view_r      <= view_nxt;
      aim_r       <= aim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    skip_r     <= skip_nxt;
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    ds_r       <= ds_nxt;
    sum_r      <= sum_nxt;
    prod_r     <= prod_nxt;
    n_r        <= n_nxt;
    rt_r       <= rt_nxt;
    bit_r      <= bit_nxt;
    rem_r      <= rem_nxt;
    qsh_r      <= qsh_nxt;
    neg_r      <= neg_nxt;
    cx_r       <= cx_nxt;
    cz_r       <= cz_nxt;
    ang_r      <= ang_nxt;
    xo_r       <= xo_nxt;
    zo_r       <= zo_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d[i]    = {aim_r[i][31], aim_r[i]} - {view_r[i][31], view_r[i]};
      dmag[i] = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
    end
    mx = dmag[0];
    if (dmag[1] > mx) mx = dmag[1];
    if (dmag[2] > mx) mx = dmag[2];
  end

  always_comb begin
    unique case (state_r)
      ST_ZSQ:   begin mul_a = 33'(ds_r[idx_r]); mul_b = 32'(ds_r[idx_r]); end
      ST_ZMUL:  begin mul_a = 33'(ds_r[idx_r]); mul_b = item_r.zoom_amount; end
      ST_RMULX: begin mul_a = xo_r;             mul_b = GAIN_Q30;           end
      ST_RMULZ: begin mul_a = zo_r;             mul_b = GAIN_Q30;           end
      default:  begin mul_a = xo_r;             mul_b = GAIN_Q30;           end
    endcase
    prod_nxt = 65'(mul_a) * 65'(mul_b);
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    view_nxt      = view_r;
    aim_nxt       = aim_r;
    skip_nxt      = skip_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    ds_nxt        = ds_r;
    sum_nxt       = sum_r;
    n_nxt         = n_r;
    rt_nxt        = rt_r;
    bit_nxt       = bit_r;
    rem_nxt       = rem_r;
    qsh_nxt       = qsh_r;
    neg_nxt       = neg_r;
    cx_nxt        = cx_r;
    cz_nxt        = cz_r;
    ang_nxt       = ang_r;
    xo_nxt        = xo_r;
    zo_nxt        = zo_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    trial  = rt_r + bit_r;
    dtrial = {rem_r, qsh_r[31]};
    pmag   = prod_r[64] ? 62'(-prod_r) : 62'(prod_r);
    prnd   = (prod_r + 65'sd8192) >>> 14;
    cxv    = cx_r;
    czv    = prnd[51:0];
    dx     = cz_r >>> cnt_r;
    dz     = cx_r >>> cnt_r;
    at     = 34'({4'b0, atan_lut(cnt_r)});
    rxs    = (cx_r + 52'sd32768) >>> 16;
    rzs    = (cz_r + 52'sd32768) >>> 16;
    qs     = neg_r ? -$signed({1'b0, qsh_r}) : $signed({1'b0, qsh_r});

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          skip_nxt = 1'b0;
          ang_nxt  = {{2{in_data.rotation_angle[15]}}, in_data.rotation_angle, 16'b0};
          unique case (in_data.operation)
            OP_MOVE:   state_nxt = ST_MOVE;
            OP_ZOOM:   state_nxt = ST_ZPREP;
            OP_ROTATE: state_nxt = ST_RPREP;
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_MOVE: begin
        view_nxt[0] = sat32(40'(view_r[0]) + 40'(item_r.delta_x));
        view_nxt[1] = sat32(40'(view_r[1]) + 40'(item_r.delta_y));
        view_nxt[2] = sat32(40'(view_r[2]) + 40'(item_r.delta_z));
        aim_nxt[0]  = sat32(40'(aim_r[0]) + 40'(item_r.delta_x));
        aim_nxt[1]  = sat32(40'(aim_r[1]) + 40'(item_r.delta_y));
        aim_nxt[2]  = sat32(40'(aim_r[2]) + 40'(item_r.delta_z));
        state_nxt   = ST_DONE;
      end
      ST_ZPREP: begin
        for (int i = 0; i < 3; i++) begin
          if (mx < 33'h040000000) begin
            ds_nxt[i] = d[i][30:0];
          end else if (mx < 33'h080000000) begin
            ds_nxt[i] = 31'(d[i] >>> 1);
          end else if (mx < 33'h100000000) begin
            ds_nxt[i] = 31'(d[i] >>> 2);
          end else begin
            ds_nxt[i] = 31'(d[i] >>> 3);
          end
        end
        sum_nxt = '0;
        idx_nxt = 2'd0;
        if (mx == '0) begin
          skip_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_ZSQ;
        end
      end
      ST_ZSQ: begin
        if (idx_r != 2'd0) sum_nxt = sum_r + prod_r[61:0];
        if (idx_r == 2'd2) begin
          state_nxt = ST_ZSUM;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
      ST_ZSUM: begin
        n_nxt     = {1'b0, sum_r + prod_r[61:0]};
        rt_nxt    = '0;
        bit_nxt   = 63'(1) << 62;
        cnt_nxt   = 5'd31;
        state_nxt = ST_ZSQRT;
      end
      ST_ZSQRT: begin
        if (n_r >= trial) begin
          n_nxt  = n_r - trial;
          rt_nxt = (rt_r >> 1) + bit_r;
        end else begin
          rt_nxt = rt_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          idx_nxt   = 2'd0;
          state_nxt = ST_ZMUL;
        end
      end
      ST_ZMUL: begin
        state_nxt = ST_ZDINIT;
      end
      ST_ZDINIT: begin
        neg_nxt   = prod_r[64];
        rem_nxt   = {2'b0, pmag[61:32]};
        qsh_nxt   = pmag[31:0];
        cnt_nxt   = 5'd31;
        state_nxt = ST_ZDIV;
      end
      ST_ZDIV: begin
        if (dtrial >= {2'b0, rt_r[30:0]}) begin
          rem_nxt = 32'(dtrial - {2'b0, rt_r[30:0]});
          qsh_nxt = {qsh_r[30:0], 1'b1};
        end else begin
          rem_nxt = dtrial[31:0];
          qsh_nxt = {qsh_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) state_nxt = ST_ZUPD;
      end
      ST_ZUPD: begin
        view_nxt[idx_r] = sat32(40'(view_r[idx_r]) + 40'(qs));
        if (idx_r == 2'd2) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = ST_ZMUL;
        end
      end
      ST_RPREP: begin
        xo_nxt = {view_r[0][31], view_r[0]} - {aim_r[0][31], aim_r[0]};
        zo_nxt = {view_r[2][31], view_r[2]} - {aim_r[2][31], aim_r[2]};
        if (view_r[0] == aim_r[0] && view_r[2] == aim_r[2]) begin
          skip_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_RMULX;
        end
      end
      ST_RMULX: begin
        state_nxt = ST_RMULZ;
      end
      ST_RMULZ: begin
        cx_nxt    = prnd[51:0];
        state_nxt = ST_RSCALE;
      end
      ST_RSCALE: begin
        cx_nxt = cxv;
        cz_nxt = czv;
        if (ang_r > QUARTER_TURN) begin
          cx_nxt  = -cxv;
          cz_nxt  = -czv;
          ang_nxt = ang_r - HALF_TURN;
        end else if (ang_r < -QUARTER_TURN) begin
          cx_nxt  = -cxv;
          cz_nxt  = -czv;
          ang_nxt = ang_r + HALF_TURN;
        end
        cnt_nxt   = 5'd0;
        state_nxt = ST_RCORD;
      end
      ST_RCORD: begin
        if (!ang_r[33]) begin
          cx_nxt  = cx_r - dx;
          cz_nxt  = cz_r + dz;
          ang_nxt = ang_r - at;
        end else begin
          cx_nxt  = cx_r + dx;
          cz_nxt  = cz_r - dz;
          ang_nxt = ang_r + at;
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(CordicIters - 1)) state_nxt = ST_RUPD;
      end
      ST_RUPD: begin
        view_nxt[0] = sat32(40'(aim_r[0]) + 40'($signed(rxs[35:0])));
        view_nxt[2] = sat32(40'(aim_r[2]) + 40'($signed(rzs[35:0])));
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{view_x: view_r[0], view_y: view_r[1], view_z: view_r[2],
                            aim_x: aim_r[0], aim_y: aim_r[1], aim_z: aim_r[2],
                            skipped: skip_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire
